### rtl/core/ipv6tp_pkg.sv
// shared types and constants for the ipv6 text address parser
// no dependencies; imported by every module in rtl/core

package ipv6tp_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned GroupW    = 16;
  localparam int unsigned PosW      = 5;
  localparam int unsigned NumGroups = 8;
  localparam int unsigned GroupIdxW = 3;
  localparam int unsigned HalfW     = 64;

  localparam logic [PosW-1:0]  FinalPos = 5'd14;
  localparam logic [PosW-1:0]  PosStep  = 5'd2;
  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CharColon = 8'h3a;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharLowF  = 8'h66;
  localparam logic [CharW-1:0] CharUpA   = 8'h41;
  localparam logic [CharW-1:0] CharUpF   = 8'h46;

  typedef struct packed {
    logic       is_nul;
    logic       is_colon;
    logic       is_hex;
    logic [3:0] nibble;
  } char_class_t;

endpackage

### rtl/core/ipv6tp_char_decode.sv
// character classifier: nul, colon, hex digit and its nibble value
// depends on ipv6tp_pkg

module ipv6tp_char_decode
  import ipv6tp_pkg::*;
(
  input  logic [CharW-1:0] char_i,
  output char_class_t      class_o
);

  logic             is_dec;
  logic             is_low;
  logic             is_up;
  logic [CharW-1:0] diff;

  always_comb begin
    is_dec = (char_i >= CharZero) && (char_i <= CharNine);
    is_low = (char_i >= CharLowA) && (char_i <= CharLowF);
    is_up  = (char_i >= CharUpA) && (char_i <= CharUpF);
    if (is_dec) begin
      diff = char_i - CharZero;
    end else if (is_low) begin
      diff = char_i - CharLowA + 8'd10;
    end else begin
      diff = char_i - CharUpA + 8'd10;
    end
    class_o.is_nul   = (char_i == CharNul);
    class_o.is_colon = (char_i == CharColon);
    class_o.is_hex   = is_dec || is_low || is_up;
    class_o.nibble   = diff[3:0];
  end

endmodule

### rtl/core/ipv6tp_assembler.sv
// group and address assembly state with the registered result stage
// depends on ipv6tp_pkg; fed by ipv6tp_char_decode through the top level

module ipv6tp_assembler
  import ipv6tp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  char_class_t      item_class_i,
  output logic             item_take_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HalfW-1:0] address_high_o,
  output logic [HalfW-1:0] address_low_o,
  output logic             address_valid_o
);

  logic [GroupW-1:0] group_q, group_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              err_q, err_d;
  logic [GroupW-1:0] slot_q [NumGroups];
  logic              slot_we;
  logic [GroupIdxW-1:0] slot_idx;
  logic              clear;
  logic              step;
  logic              ok;
  logic              out_valid_q, out_valid_d;
  logic [HalfW-1:0]  high_q, low_q;
  logic              avalid_q;

  assign item_take_o = !item_class_i.is_nul || !out_valid_q || out_ready_i;
  assign step        = item_valid_i && item_take_o;
  assign ok          = !err_q && (pos_q == FinalPos);
  assign slot_idx    = pos_q[GroupIdxW:1];
  assign clear       = step && item_class_i.is_nul;

  always_comb begin
    group_d = group_q;
    pos_d   = pos_q;
    err_d   = err_q;
    slot_we = 1'b0;
    if (step) begin
      if (item_class_i.is_nul) begin
        group_d = '0;
        pos_d   = '0;
        err_d   = 1'b0;
      end else if (!err_q) begin
        if (item_class_i.is_colon) begin
          if (pos_q >= FinalPos) begin
            err_d = 1'b1;
          end else begin
            slot_we = 1'b1;
            pos_d   = pos_q + PosStep;
            group_d = '0;
          end
        end else if (item_class_i.is_hex) begin
          group_d = {group_q[GroupW-5:0], item_class_i.nibble};
        end else begin
          err_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      pos_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      group_q <= group_d;
      pos_q   <= pos_d;
      err_q   <= err_d;
    end
  end

  // group slots, cleared at the end of each string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumGroups; i++) begin
        slot_q[i] <= '0;
      end
    end else if (clear) begin
      for (int i = 0; i < NumGroups; i++) begin
        slot_q[i] <= '0;
      end
    end else if (slot_we) begin
      slot_q[slot_idx] <= group_q;
    end
  end

  // result register
  assign out_valid_d = (out_valid_q && !out_ready_i) || clear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      avalid_q <= ok;
      if (ok) begin
        high_q <= {slot_q[0], slot_q[1], slot_q[2], slot_q[3]};
        low_q  <= {slot_q[4], slot_q[5], slot_q[6], group_q};
      end else begin
        high_q <= '0;
        low_q  <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign address_high_o  = high_q;
  assign address_low_o   = low_q;
  assign address_valid_o = avalid_q;

`ifndef SYNTHESIS
  a_pos_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pos_q[0] && (pos_q <= FinalPos))
    else $error("byte position odd or past the last group");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !avalid_q) |-> (high_q == '0) && (low_q == '0))
    else $error("invalid result carries a non-zero address");

  a_clear_after_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (pos_q == '0) && (group_q == '0) && !err_q && out_valid_q)
    else $error("state not cleared after end of string");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !clear)
    else $error("result overwritten while waiting");
`endif

endmodule

### rtl/core/ipv6_text_address_parser.sv
// a nul request, once accepted, passes the input register and then the result register
// to give its result; throughput one character per cycle while no nul stalls
// the input register refills while a result waits; only a nul stalls then
// reset: asynchronous active low, clears group, position, error and all slots
// top level of the ipv6 text address parser; depends on ipv6tp_pkg,
// ipv6tp_char_decode and ipv6tp_assembler

module ipv6_text_address_parser
  import ipv6tp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] text_char_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HalfW-1:0] address_high_o,
  output logic [HalfW-1:0] address_low_o,
  output logic             address_valid_o
);

  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] char_q;
  logic             take;
  logic             accept;
  char_class_t      cls;

  assign in_ready_o = !in_valid_q || take;
  assign accept     = in_valid_i && in_ready_o;
  assign in_valid_d = accept || (in_valid_q && !take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= text_char_i;
    end
  end

  ipv6tp_char_decode u_decode (
    .char_i  (char_q),
    .class_o (cls)
  );

  ipv6tp_assembler u_assembler (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (in_valid_q),
    .item_class_i    (cls),
    .item_take_o     (take),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .address_high_o  (address_high_o),
    .address_low_o   (address_low_o),
    .address_valid_o (address_valid_o)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for ipv6_text_address_parser: address strings, broken strings
// and noise go in one character per request; every result is checked against a predictor
// depends on ipv6tp_pkg and the ipv6_text_address_parser rtl

module tb_top;
  import ipv6tp_pkg::*;

  typedef struct packed {
    logic [HalfW-1:0] hi;
    logic [HalfW-1:0] lo;
    logic             ok;
  } addr_result_t;

  typedef enum logic [1:0] {RdyAlways, RdyCoin, RdyQuarter, RdySparse} rdy_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [CharW-1:0] text_char_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [HalfW-1:0] address_high_o;
  logic [HalfW-1:0] address_low_o;
  logic             address_valid_o;

  logic [CharW-1:0] char_q[$];
  addr_result_t     addr_expect_q[$];

  logic [GroupW-1:0] grp_acc = '0;
  logic [PosW-1:0]   byte_pos = '0;
  logic [HalfW-1:0]  addr_word[2] = '{default: '0};
  logic              str_bad = 1'b0;

  logic      req_took = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        mode_left = 0;
  rdy_mode_e stall_mode = RdyAlways;
  int        results_seen = 0;
  int        err_cnt = 0;

  ipv6_text_address_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_char_i    (text_char_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .address_high_o (address_high_o),
    .address_low_o  (address_low_o),
    .address_valid_o(address_valid_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int nibble_of(input logic [CharW-1:0] c);
    if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
    if (c >= CharLowA && c <= CharLowF) return int'(c - CharLowA) + 10;
    if (c >= CharUpA && c <= CharUpF) return int'(c - CharUpA) + 10;
    return -1;
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return CharZero + nib;
    return (upper ? CharUpA : CharLowA) + nib - 8'd10;
  endfunction

  task automatic place_group(input logic [PosW-1:0] pos);
    logic [GroupIdxW-1:0] gi;
    gi = pos[GroupIdxW:1];
    addr_word[gi[2]] |= {48'b0, grp_acc} << (16 * (3 - int'(gi[1:0])));
  endtask

  task automatic parse_char(input logic [CharW-1:0] c);
    addr_result_t r;
    int nib;
    if (c == CharNul) begin
      r = '0;
      if (!str_bad && byte_pos == FinalPos) begin
        place_group(FinalPos);
        r = '{addr_word[0], addr_word[1], 1'b1};
      end
      addr_expect_q.push_back(r);
      grp_acc = '0;
      byte_pos = '0;
      addr_word = '{default: '0};
      str_bad = 1'b0;
    end else if (!str_bad) begin
      if (c == CharColon) begin
        if (byte_pos >= FinalPos) begin
          str_bad = 1'b1;
        end else begin
          place_group(byte_pos);
          byte_pos = byte_pos + PosStep;
          grp_acc = '0;
        end
      end else begin
        nib = nibble_of(c);
        if (nib < 0) begin
          str_bad = 1'b1;
        end else begin
          grp_acc = {grp_acc[GroupW-5:0], nib[3:0]};
        end
      end
    end
  endtask

  task automatic push_text(input string txt);
    foreach (txt[i]) char_q.push_back(txt[i]);
    char_q.push_back(CharNul);
  endtask

  // groups of up to six digits in mixed case, optionally one illegal character
  task automatic push_address(input int ncolon, input bit add_junk);
    logic [CharW-1:0] s[$];
    logic [CharW-1:0] junk;
    int ndig;
    for (int g = 0; g <= ncolon; g++) begin
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
      repeat (ndig) s.push_back(hex_char(4'($urandom_range(0, 15)),
                                         1'($urandom_range(0, 1))));
      if (g < ncolon) s.push_back(CharColon);
    end
    if (add_junk) begin
      do junk = 8'($urandom_range(1, 255));
      while (junk == CharColon || nibble_of(junk) >= 0);
      s.insert($urandom_range(0, s.size()), junk);
    end
    s.push_back(CharNul);
    foreach (s[i]) char_q.push_back(s[i]);
  endtask

  // sender: bursts of random length with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_took)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (char_q.size() > 0) begin
        in_valid_i <= 1'b1;
        text_char_i <= char_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: changing stall patterns plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= 20) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= rdy_mode_e'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        RdyAlways:  out_ready_i <= 1'b1;
        RdyCoin:    out_ready_i <= 1'($urandom_range(0, 1));
        RdyQuarter: out_ready_i <= (mode_left % 4 == 0);
        default:    out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : monitor
    addr_result_t want;
    if (rst_ni) begin
      req_took <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) parse_char(text_char_i);
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (addr_expect_q.size() == 0) begin
          $error("result with no request pending: high %h low %h valid %b",
                 address_high_o, address_low_o, address_valid_o);
          err_cnt++;
        end else begin
          want = addr_expect_q.pop_front();
          if (address_high_o !== want.hi) begin
            $error("address_high: expected %h, got %h", want.hi, address_high_o);
            err_cnt++;
          end
          if (address_low_o !== want.lo) begin
            $error("address_low: expected %h, got %h", want.lo, address_low_o);
            err_cnt++;
          end
          if (address_valid_o !== want.ok) begin
            $error("address_valid: expected %b, got %b", want.ok, address_valid_o);
            err_cnt++;
          end
        end
      end
    end else begin
      req_took <= 1'b0;
    end
  end

  initial begin
    int pick;
    int n;
    push_text("");
    push_text(":0:9:a:f:A:F:");
    push_text("::::::::");
    push_text(":g:");
    char_q.push_back(8'hff);
    char_q.push_back(CharNul);
    while (char_q.size() < 1680) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        push_address(7, 1'b0);
      end else if (pick < 15) begin
        push_address(7, 1'b1);
      end else if (pick < 17) begin
        n = $urandom_range(0, 8);
        if (n == 7) n = 9;
        push_address(n, 1'b0);
      end else begin
        repeat ($urandom_range(1, 8)) char_q.push_back(8'($urandom_range(1, 255)));
        char_q.push_back(CharNul);
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (char_q.size() != 0 || in_valid_i || addr_expect_q.size() != 0);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && addr_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ipv6tp_pkg.sv
rtl/core/ipv6tp_char_decode.sv
rtl/core/ipv6tp_assembler.sv
rtl/core/ipv6_text_address_parser.sv
tb/tb_top.sv
